// ===== rtl/owtr_pkg.sv =====
package owtr_pkg;

  typedef enum logic [4:0] {
    PH_IDLE,
    PH_R1_LOW,
    PH_R1_WAIT,
    PH_R1_REC,
    PH_W_SKIP1,
    PH_W_CONV,
    PH_CONVERT,
    PH_R2_LOW,
    PH_R2_WAIT,
    PH_R2_REC,
    PH_W_SKIP2,
    PH_W_READ,
    PH_READ,
    PH_DONE
  } phase_t;

  typedef enum logic [2:0] {
    REG_RESET_LOW,
    REG_PRESENCE_WAIT,
    REG_RESET_RECOVER,
    REG_READ_SAMPLE,
    REG_READ_TAIL,
    REG_WRITE_SLOT,
    REG_CONVERSION
  } reg_index_t;

  localparam logic [7:0] CMD_SKIP_ROM  = 8'hCC;
  localparam logic [7:0] CMD_CONVERT   = 8'h44;
  localparam logic [7:0] CMD_READ_PAD  = 8'hBE;
  localparam logic [7:0] CRC_POLY      = 8'h8C;

  localparam logic [9:0]  RESET_LOW_DEFAULT     = 10'd480;
  localparam logic [7:0]  PRESENCE_WAIT_DEFAULT = 8'd70;
  localparam logic [9:0]  RESET_RECOVER_DEFAULT = 10'd240;
  localparam logic [5:0]  READ_SAMPLE_DEFAULT   = 6'd15;
  localparam logic [7:0]  READ_TAIL_DEFAULT     = 8'd160;
  localparam logic [7:0]  WRITE_SLOT_DEFAULT    = 8'd100;
  localparam logic [19:0] CONVERSION_DEFAULT    = 20'd750000;

  function automatic logic [7:0] crc8_update(input logic [7:0] crc, input logic [7:0] data);
    logic [7:0] c;
    c = crc ^ data;
    for (int i = 0; i < 8; i++) begin
      c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
    end
    return c;
  endfunction

endpackage

// ===== rtl/one_wire_temperature_reader_top.sv =====
// A result word is registered and appears on the output in the cycle after its tick word is accepted.
// Throughput: one tick word per cycle, as long as the single output register is empty or
// being drained in the same cycle; no tick is taken while the last result waits.
// Reset (rst_n low, synchronous): sequencer idle, internal flags and result cleared,
// output valid cleared, timing registers back to their default microsecond values.
module one_wire_temperature_reader_top #(
  parameter int SCRATCH_BYTES = 9
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        in_start_req,
  input  logic        in_line_level,
  output logic        out_valid,
  input  logic        out_ready,
  output logic        out_drive_low,
  output logic        out_pullup_on,
  output logic        out_busy_res,
  output logic        out_done_res,
  output logic        out_crc_good,
  output logic        out_presence_seen,
  output logic signed [15:0] out_temperature,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [19:0] cfg_data
);

  localparam logic [3:0] LAST_BYTE = 4'(SCRATCH_BYTES - 1);

  logic [9:0]  reset_low_r;
  logic [7:0]  presence_wait_r;
  logic [9:0]  reset_recover_r;
  logic [5:0]  read_sample_r;
  logic [7:0]  read_tail_r;
  logic [7:0]  write_slot_r;
  logic [19:0] conversion_r;

  owtr_pkg::phase_t phase_r, phase_nxt, phase_eff;
  logic [19:0] tick_timer_r, tick_timer_nxt, tt_eff;
  logic [2:0]  bit_index_r, bit_index_nxt;
  logic [3:0]  byte_index_r, byte_index_nxt;
  logic [7:0]  shift_byte_r, shift_byte_nxt;
  logic [7:0]  crc_acc_r, crc_acc_nxt;
  logic [7:0]  temp_low_r, temp_low_nxt;
  logic [7:0]  temp_high_r, temp_high_nxt;
  logic        presence_r, presence_nxt;
  logic [15:0] result_r, result_nxt;
  logic        crc_flag_r, crc_flag_nxt;

  logic        drive, pull, busy, done;
  logic        accept;
  logic        out_valid_r;

  logic [20:0] tt_inc;
  logic [20:0] lim_reset_low, lim_wait, lim_recover, lim_conv;
  logic [20:0] lim_write, lim_read;
  logic [7:0]  ws;
  logic [5:0]  rs;
  logic [7:0]  rt;
  logic [7:0]  shifted_in;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      reset_low_r     <= owtr_pkg::RESET_LOW_DEFAULT;
      presence_wait_r <= owtr_pkg::PRESENCE_WAIT_DEFAULT;
      reset_recover_r <= owtr_pkg::RESET_RECOVER_DEFAULT;
      read_sample_r   <= owtr_pkg::READ_SAMPLE_DEFAULT;
      read_tail_r     <= owtr_pkg::READ_TAIL_DEFAULT;
      write_slot_r    <= owtr_pkg::WRITE_SLOT_DEFAULT;
      conversion_r    <= owtr_pkg::CONVERSION_DEFAULT;
    end else if (cfg_valid) begin
      case (owtr_pkg::reg_index_t'(cfg_index))
        owtr_pkg::REG_RESET_LOW:     reset_low_r     <= cfg_data[9:0];
        owtr_pkg::REG_PRESENCE_WAIT: presence_wait_r <= cfg_data[7:0];
        owtr_pkg::REG_RESET_RECOVER: reset_recover_r <= cfg_data[9:0];
        owtr_pkg::REG_READ_SAMPLE:   read_sample_r   <= cfg_data[5:0];
        owtr_pkg::REG_READ_TAIL:     read_tail_r     <= cfg_data[7:0];
        owtr_pkg::REG_WRITE_SLOT:    write_slot_r    <= cfg_data[7:0];
        owtr_pkg::REG_CONVERSION:    conversion_r    <= cfg_data;
        default: ;
      endcase
    end
  end

  // zero in a duration register acts as one
  assign ws = (write_slot_r == '0) ? 8'd1 : write_slot_r;
  assign rs = (read_sample_r == '0) ? 6'd1 : read_sample_r;
  assign rt = (read_tail_r == '0) ? 8'd1 : read_tail_r;
  assign lim_reset_low = (reset_low_r == '0) ? 21'd1 : {11'd0, reset_low_r};
  assign lim_wait      = (presence_wait_r == '0) ? 21'd1 : {13'd0, presence_wait_r};
  assign lim_recover   = (reset_recover_r == '0) ? 21'd1 : {11'd0, reset_recover_r};
  assign lim_conv      = (conversion_r == '0) ? 21'd1 : {1'b0, conversion_r};
  assign lim_write     = {13'd0, ws};
  assign lim_read      = {12'd0, {3'd0, rs} + {1'b0, rt}};

  assign phase_eff = (phase_r == owtr_pkg::PH_IDLE && in_start_req) ? owtr_pkg::PH_R1_LOW
                                                                     : phase_r;
  assign tt_eff    = (phase_r == owtr_pkg::PH_IDLE) ? 20'd0 : tick_timer_r;
  assign tt_inc    = {1'b0, tt_eff} + 21'd1;
  assign shifted_in = {in_line_level, shift_byte_r[7:1]};

  always_comb begin
    logic [7:0] sb;
    logic [7:0] crc_new;
    logic [7:0] lo;
    logic [7:0] hi;
    logic       good;
    phase_nxt      = phase_eff;
    tick_timer_nxt = tt_inc[19:0];
    bit_index_nxt  = bit_index_r;
    byte_index_nxt = byte_index_r;
    shift_byte_nxt = shift_byte_r;
    crc_acc_nxt    = crc_acc_r;
    temp_low_nxt   = temp_low_r;
    temp_high_nxt  = temp_high_r;
    presence_nxt   = presence_r;
    result_nxt     = result_r;
    crc_flag_nxt   = crc_flag_r;
    sb      = '0;
    crc_new = '0;
    lo      = '0;
    hi      = '0;
    good    = 1'b0;
    case (phase_eff)
      owtr_pkg::PH_R1_LOW, owtr_pkg::PH_R2_LOW: begin
        if (tt_inc >= lim_reset_low) begin
          phase_nxt = (phase_eff == owtr_pkg::PH_R1_LOW) ? owtr_pkg::PH_R1_WAIT
                                                         : owtr_pkg::PH_R2_WAIT;
          tick_timer_nxt = '0;
        end
      end
      owtr_pkg::PH_R1_WAIT, owtr_pkg::PH_R2_WAIT: begin
        if (tt_inc >= lim_wait) begin
          phase_nxt = (phase_eff == owtr_pkg::PH_R1_WAIT) ? owtr_pkg::PH_R1_REC
                                                          : owtr_pkg::PH_R2_REC;
          tick_timer_nxt = '0;
        end
      end
      owtr_pkg::PH_R1_REC, owtr_pkg::PH_R2_REC: begin
        if (tt_eff == '0) begin
          presence_nxt = ~in_line_level;
        end
        if (tt_inc >= lim_recover) begin
          phase_nxt = (phase_eff == owtr_pkg::PH_R1_REC) ? owtr_pkg::PH_W_SKIP1
                                                         : owtr_pkg::PH_W_SKIP2;
          tick_timer_nxt = '0;
          bit_index_nxt  = '0;
          shift_byte_nxt = owtr_pkg::CMD_SKIP_ROM;
        end
      end
      owtr_pkg::PH_W_SKIP1, owtr_pkg::PH_W_CONV, owtr_pkg::PH_W_SKIP2,
      owtr_pkg::PH_W_READ: begin
        if (tt_inc > lim_write) begin
          tick_timer_nxt = '0;
          shift_byte_nxt = {1'b0, shift_byte_r[7:1]};
          if (bit_index_r == 3'd7) begin
            bit_index_nxt = '0;
            case (phase_eff)
              owtr_pkg::PH_W_SKIP1: begin
                shift_byte_nxt = owtr_pkg::CMD_CONVERT;
                phase_nxt      = owtr_pkg::PH_W_CONV;
              end
              owtr_pkg::PH_W_CONV: begin
                phase_nxt = owtr_pkg::PH_CONVERT;
              end
              owtr_pkg::PH_W_SKIP2: begin
                shift_byte_nxt = owtr_pkg::CMD_READ_PAD;
                phase_nxt      = owtr_pkg::PH_W_READ;
              end
              default: begin
                shift_byte_nxt = '0;
                byte_index_nxt = '0;
                crc_acc_nxt    = '0;
                phase_nxt      = owtr_pkg::PH_READ;
              end
            endcase
          end else begin
            bit_index_nxt = bit_index_r + 3'd1;
          end
        end
      end
      owtr_pkg::PH_CONVERT: begin
        if (tt_inc >= lim_conv) begin
          phase_nxt      = owtr_pkg::PH_R2_LOW;
          tick_timer_nxt = '0;
        end
      end
      owtr_pkg::PH_READ: begin
        sb = (tt_eff == {14'd0, rs}) ? shifted_in : shift_byte_r;
        shift_byte_nxt = sb;
        if (tt_inc > lim_read) begin
          tick_timer_nxt = '0;
          if (bit_index_r == 3'd7) begin
            bit_index_nxt = '0;
            crc_new     = owtr_pkg::crc8_update(crc_acc_r, sb);
            crc_acc_nxt = crc_new;
            lo = (byte_index_r == 4'd0) ? sb : temp_low_r;
            hi = (byte_index_r == 4'd1) ? sb : temp_high_r;
            temp_low_nxt  = lo;
            temp_high_nxt = hi;
            if (byte_index_r >= LAST_BYTE) begin
              good         = (crc_new == '0);
              crc_flag_nxt = good;
              result_nxt   = good ? {hi, lo} : 16'd0;
              phase_nxt    = owtr_pkg::PH_DONE;
            end else begin
              byte_index_nxt = byte_index_r + 4'd1;
            end
          end else begin
            bit_index_nxt = bit_index_r + 3'd1;
          end
        end
      end
      owtr_pkg::PH_DONE: begin
        phase_nxt      = owtr_pkg::PH_IDLE;
        tick_timer_nxt = tick_timer_r;
      end
      default: begin
        phase_nxt      = owtr_pkg::PH_IDLE;
        tick_timer_nxt = '0;
      end
    endcase
  end

  always_comb begin
    drive = 1'b0;
    pull  = 1'b0;
    busy  = 1'b1;
    done  = 1'b0;
    case (phase_eff)
      owtr_pkg::PH_R1_LOW, owtr_pkg::PH_R2_LOW: begin
        drive = 1'b1;
      end
      owtr_pkg::PH_W_SKIP1, owtr_pkg::PH_W_CONV, owtr_pkg::PH_W_SKIP2,
      owtr_pkg::PH_W_READ: begin
        if (tt_eff == '0) begin
          drive = 1'b1;
        end else if (tt_eff < {12'd0, ws}) begin
          drive = ~shift_byte_r[0];
        end
      end
      owtr_pkg::PH_READ: begin
        drive = (tt_eff == '0);
      end
      owtr_pkg::PH_CONVERT: begin
        pull = 1'b1;
      end
      owtr_pkg::PH_DONE: begin
        busy = 1'b0;
        done = 1'b1;
      end
      owtr_pkg::PH_IDLE: begin
        busy = 1'b0;
      end
      default: ;
    endcase
  end

  assign in_ready = !out_valid_r || out_ready;
  assign accept   = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r      <= owtr_pkg::PH_IDLE;
      tick_timer_r <= '0;
      bit_index_r  <= '0;
      byte_index_r <= '0;
      shift_byte_r <= '0;
      crc_acc_r    <= '0;
      temp_low_r   <= '0;
      temp_high_r  <= '0;
      presence_r   <= 1'b0;
      result_r     <= '0;
      crc_flag_r   <= 1'b0;
    end else if (accept) begin
      phase_r      <= phase_nxt;
      tick_timer_r <= tick_timer_nxt;
      bit_index_r  <= bit_index_nxt;
      byte_index_r <= byte_index_nxt;
      shift_byte_r <= shift_byte_nxt;
      crc_acc_r    <= crc_acc_nxt;
      temp_low_r   <= temp_low_nxt;
      temp_high_r  <= temp_high_nxt;
      presence_r   <= presence_nxt;
      result_r     <= result_nxt;
      crc_flag_r   <= crc_flag_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (accept) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      out_drive_low     <= drive;
      out_pullup_on     <= pull;
      out_busy_res      <= busy;
      out_done_res      <= done;
      out_crc_good      <= crc_flag_nxt;
      out_presence_seen <= presence_nxt;
      out_temperature   <= result_nxt;
    end
  end

  assign out_valid = out_valid_r;

  a_done_not_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_done_res |-> !out_busy_res)
    else $error("done word reports busy");

  a_drive_vs_pullup: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> !(out_drive_low && out_pullup_on))
    else $error("bus driven low while strong pullup on");

  a_fail_gives_zero: assert property (@(posedge clk) disable iff (!rst_n)
    !crc_flag_r |-> result_r == 16'd0)
    else $error("nonzero temperature without good crc");

  a_accept_fills_output: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> out_valid_r)
    else $error("accepted tick produced no result word");

  a_done_returns_idle: assert property (@(posedge clk) disable iff (!rst_n)
    accept && phase_r == owtr_pkg::PH_DONE |=> phase_r == owtr_pkg::PH_IDLE)
    else $error("sequencer did not return to idle after done");

endmodule
